// ----- rtl/fsge_pkg.sv -----
// Package with the request codes, field widths and controller states of the sand grid engine.
package fsge_pkg;

  localparam int REQ_W = 2;
  localparam int POS_X_W = 8;
  localparam int POS_Y_W = 7;
  localparam int RADIUS_W = 6;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 8;

  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PLACE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SW_ADDR,
    ST_SW_FIRST,
    ST_SW_STEP,
    ST_SW_LAST,
    ST_PL_INIT,
    ST_PL_RD,
    ST_PL_WR,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DONE
  } fsge_state_t;

endpackage

// ----- rtl/falling_sand_grid_engine.sv -----
// Top level of the sand grid engine: row memory, sweep, brush and read sequencer.
// After reset a clearing pass writes every row to empty, one row a cycle.
// In a tick the sweep reads one row and writes one row per cycle.
// A place does one read-modify-write per brush row inside the grid.
// A read fetches one row; an unused request type goes straight to its result.
// One request is in work at a time; the row memory has one read port and one write port.
module falling_sand_grid_engine
  import fsge_pkg::*;
#(
  parameter int GRID_COLUMNS = 256,
  parameter int GRID_ROWS = 128,
  parameter int MAX_BRUSH = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0 up: pos_x[7:0], pos_y[14:8], brush_radius[20:15], zero fill.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0 up: req_type[1:0].
  input  logic [REQ_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0 up: cell_occupied[0], zero fill.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0 up: ack_kind[1:0].
  output logic [REQ_W-1:0]      m_axis_tuser
);

  localparam int CW = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int XEW = ((CW > POS_X_W) ? CW : POS_X_W) + 1;
  localparam int YEW = ((RW > POS_Y_W) ? RW : POS_Y_W) + 1;
  localparam int SXW = XEW + 1;
  localparam int SYW = YEW + 1;

  fsge_state_t state;
  fsge_state_t state_next;

  logic [GRID_COLUMNS-1:0] grid_mem [GRID_ROWS];
  logic [GRID_COLUMNS-1:0] mem_rdata;
  logic [GRID_COLUMNS-1:0] mem_wdata;
  logic [RW-1:0]           mem_raddr;
  logic [RW-1:0]           mem_waddr;
  logic                    mem_we;

  logic [REQ_W-1:0]    req_kind;
  logic [POS_X_W-1:0]  req_x;
  logic [POS_Y_W-1:0]  req_y;
  logic [RADIUS_W-1:0] req_rad;
  logic [RADIUS_W-1:0] rad_sat;

  logic [RW-1:0] row_cnt;
  logic [RW-1:0] row_cnt_next;
  logic [RW-1:0] row_end;
  logic [RW-1:0] row_end_next;

  logic [GRID_COLUMNS-1:0] carry;
  logic [GRID_COLUMNS-1:0] carry_next;
  logic [GRID_COLUMNS-1:0] brush_mask;

  logic signed [SXW-1:0] col_lo;
  logic signed [SXW-1:0] col_hi;
  logic signed [SXW-1:0] col_lo_next;
  logic signed [SXW-1:0] col_hi_next;
  logic signed [SXW-1:0] x_s;
  logic signed [SXW-1:0] xr_s;
  logic signed [SXW-1:0] x_lo_s;
  logic signed [SXW-1:0] x_hi_s;
  logic signed [SYW-1:0] y_s;
  logic signed [SYW-1:0] yr_s;
  logic signed [SYW-1:0] y_lo_s;
  logic signed [SYW-1:0] y_hi_s;
  logic signed [SYW-1:0] y_lo_c;
  logic signed [SYW-1:0] y_hi_c;

  logic [XEW-1:0] x_ext;
  logic [YEW-1:0] y_ext;
  logic           rd_in_grid;

  logic res_occ;
  logic res_occ_next;
  logic out_valid;
  logic out_occ;
  logic [REQ_W-1:0] out_kind;
  logic out_load;
  logic in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {{(OUT_DATA_W - 1){1'b0}}, out_occ};

  assign rad_sat = ({3'b000, req_rad} > 9'(MAX_BRUSH)) ? RADIUS_W'(MAX_BRUSH) : req_rad;

  assign x_s = SXW'(req_x);
  assign xr_s = SXW'(rad_sat);
  assign x_lo_s = x_s - xr_s;
  assign x_hi_s = x_s + xr_s - SXW'(1);
  assign y_s = SYW'(req_y);
  assign yr_s = SYW'(rad_sat);
  assign y_lo_s = y_s - yr_s;
  assign y_hi_s = y_s + yr_s - SYW'(1);
  assign y_lo_c = (y_lo_s < SYW'(0)) ? SYW'(0) : y_lo_s;
  assign y_hi_c = (y_hi_s > SYW'(GRID_ROWS - 1)) ? SYW'(GRID_ROWS - 1) : y_hi_s;

  assign x_ext = XEW'(req_x);
  assign y_ext = YEW'(req_y);
  assign rd_in_grid = (x_ext < XEW'(GRID_COLUMNS)) && (y_ext < YEW'(GRID_ROWS));

  always_comb begin
    for (int c = 0; c < GRID_COLUMNS; c++) begin
      brush_mask[c] = (SXW'(c) >= col_lo) && (SXW'(c) <= col_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= grid_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      row_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      row_cnt <= row_cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_kind <= s_axis_tuser;
      req_x <= s_axis_tdata[7:0];
      req_y <= s_axis_tdata[14:8];
      req_rad <= s_axis_tdata[20:15];
    end
    if (out_load) begin
      out_kind <= req_kind;
      out_occ <= res_occ;
    end
    carry <= carry_next;
    row_end <= row_end_next;
    col_lo <= col_lo_next;
    col_hi <= col_hi_next;
    res_occ <= res_occ_next;
  end

  always_comb begin
    state_next = state;
    row_cnt_next = row_cnt;
    row_end_next = row_end;
    carry_next = carry;
    col_lo_next = col_lo;
    col_hi_next = col_hi;
    res_occ_next = res_occ;
    mem_raddr = row_cnt;
    mem_waddr = row_cnt;
    mem_wdata = '0;
    mem_we = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (row_cnt == RW'(GRID_ROWS - 1)) begin
          row_cnt_next = '0;
          state_next = ST_IDLE;
        end else begin
          row_cnt_next = row_cnt + RW'(1);
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          res_occ_next = 1'b0;
          case (s_axis_tuser)
            REQ_TICK: state_next = ST_SW_ADDR;
            REQ_PLACE: state_next = ST_PL_INIT;
            REQ_READ: state_next = ST_RD_ADDR;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SW_ADDR: begin
        mem_raddr = '0;
        state_next = ST_SW_FIRST;
      end
      ST_SW_FIRST: begin
        carry_next = mem_rdata;
        mem_raddr = RW'(1);
        row_cnt_next = RW'(1);
        state_next = ST_SW_STEP;
      end
      ST_SW_STEP: begin
        mem_we = 1'b1;
        mem_waddr = row_cnt - RW'(1);
        mem_wdata = carry & mem_rdata;
        carry_next = carry | mem_rdata;
        if (row_cnt == RW'(GRID_ROWS - 1)) begin
          state_next = ST_SW_LAST;
        end else begin
          mem_raddr = row_cnt + RW'(1);
          row_cnt_next = row_cnt + RW'(1);
        end
      end
      ST_SW_LAST: begin
        mem_we = 1'b1;
        mem_waddr = row_cnt;
        mem_wdata = carry;
        state_next = ST_DONE;
      end
      ST_PL_INIT: begin
        col_lo_next = (x_lo_s < SXW'(0)) ? SXW'(0) : x_lo_s;
        col_hi_next = (x_hi_s > SXW'(GRID_COLUMNS - 1)) ? SXW'(GRID_COLUMNS - 1) : x_hi_s;
        row_cnt_next = y_lo_c[RW-1:0];
        row_end_next = y_hi_c[RW-1:0];
        if ((rad_sat == '0) || (y_lo_c > y_hi_c)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_PL_RD;
        end
      end
      ST_PL_RD: begin
        mem_raddr = row_cnt;
        state_next = ST_PL_WR;
      end
      ST_PL_WR: begin
        mem_we = 1'b1;
        mem_waddr = row_cnt;
        mem_wdata = mem_rdata | brush_mask;
        if (row_cnt == row_end) begin
          state_next = ST_DONE;
        end else begin
          row_cnt_next = row_cnt + RW'(1);
          state_next = ST_PL_RD;
        end
      end
      ST_RD_ADDR: begin
        mem_raddr = y_ext[RW-1:0];
        state_next = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        res_occ_next = rd_in_grid && mem_rdata[x_ext[CW-1:0]];
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_load = 1'b1;
          row_cnt_next = '0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("row memory written while idle");

  a_occ_only_read: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != REQ_READ)) |-> !m_axis_tdata[0])
    else $error("occupied flag set on a result that is not a read");

  a_place_rmw_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PL_WR) |-> (mem_waddr == $past(mem_raddr)))
    else $error("brush write back goes to a row other than the one read");

  a_sweep_behind: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SW_STEP && row_cnt != RW'(GRID_ROWS - 1)) |-> (mem_raddr != mem_waddr))
    else $error("sweep reads the row it writes");

endmodule

// ----- test/tb_falling_sand_grid_engine.sv -----
// Self-checking testbench for the sand grid engine: directed and random requests against a grid predictor.
`timescale 1ns / 100ps

module tb_falling_sand_grid_engine;
  import fsge_pkg::*;

  localparam int COLS = 256;
  localparam int ROWS = 128;
  localparam int BRUSH_MAX = 63;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLDOFF_CYCLES = 400;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0] ack_kind;
    logic             cell_occupied;
  } sand_ack_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [REQ_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [REQ_W-1:0]      m_axis_tuser;

  bit [COLS-1:0] sand_rows [ROWS];
  sand_ack_t     pending_acks [$];
  int            mismatches;
  int            quiet_cycles;
  int            sink_hold_cycles;
  bit            src_idle_on;
  bit            sink_idle_on;
  int unsigned   last_x;
  int unsigned   last_y;

  falling_sand_grid_engine #(
    .GRID_COLUMNS(COLS),
    .GRID_ROWS(ROWS),
    .MAX_BRUSH(BRUSH_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void sweep_sand();
    bit [COLS-1:0] falling;
    for (int row = 0; row < ROWS - 1; row++) begin
      falling = sand_rows[row] & ~sand_rows[row + 1];
      sand_rows[row + 1] = sand_rows[row + 1] | falling;
      sand_rows[row] = sand_rows[row] & ~falling;
    end
  endfunction

  function automatic void fill_square(int cx, int cy, int radius);
    int half;
    half = (radius > BRUSH_MAX) ? BRUSH_MAX : radius;
    for (int row = cy - half; row < cy + half; row++) begin
      if (row >= 0 && row < ROWS) begin
        for (int col = cx - half; col < cx + half; col++) begin
          if (col >= 0 && col < COLS) sand_rows[row][col] = 1'b1;
        end
      end
    end
  endfunction

  function automatic sand_ack_t apply_request(logic [REQ_W-1:0] kind, logic [POS_X_W-1:0] x,
                                              logic [POS_Y_W-1:0] y, logic [RADIUS_W-1:0] r);
    sand_ack_t ack;
    ack.ack_kind = kind;
    ack.cell_occupied = 1'b0;
    case (kind)
      REQ_TICK: begin
        sweep_sand();
      end
      REQ_PLACE: begin
        fill_square(int'(x), int'(y), int'(r));
      end
      REQ_READ: begin
        ack.cell_occupied = sand_rows[y][x];
      end
      default: begin
      end
    endcase
    return ack;
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_X_W-1:0] x,
                              input logic [POS_Y_W-1:0] y, input logic [RADIUS_W-1:0] r);
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {{(IN_DATA_W - POS_X_W - POS_Y_W - RADIUS_W){1'b0}}, r, y, x};
    do @(posedge clk); while (!s_axis_tready);
    pending_acks.push_back(apply_request(kind, x, y, r));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_grid();
    send_request(REQ_READ, 8'd0, 7'd0, 6'd0);
    send_request(REQ_READ, 8'd255, 7'd127, 6'd63);
    send_request(REQ_TICK, 8'd255, 7'd127, 6'd63);
    send_request(REQ_PLACE, 8'd100, 7'd50, 6'd0);
    send_request(REQ_READ, 8'd100, 7'd50, 6'd0);
  endtask

  task automatic test_brush_clipping();
    send_request(REQ_PLACE, 8'd0, 7'd0, 6'd63);
    send_request(REQ_READ, 8'd0, 7'd0, 6'd0);
    send_request(REQ_READ, 8'd62, 7'd62, 6'd0);
    send_request(REQ_READ, 8'd63, 7'd0, 6'd0);
    send_request(REQ_PLACE, 8'd255, 7'd127, 6'd63);
    send_request(REQ_READ, 8'd255, 7'd127, 6'd0);
    send_request(REQ_READ, 8'd192, 7'd64, 6'd0);
    send_request(REQ_READ, 8'd191, 7'd64, 6'd0);
    send_request(REQ_PLACE, 8'd128, 7'd10, 6'd1);
    send_request(REQ_READ, 8'd127, 7'd9, 6'd0);
    send_request(REQ_READ, 8'd129, 7'd10, 6'd0);
  endtask

  task automatic test_sweep();
    send_request(REQ_TICK, 8'd0, 7'd0, 6'd0);
    send_request(REQ_READ, 8'd0, 7'd0, 6'd0);
    send_request(REQ_READ, 8'd0, 7'd62, 6'd0);
    send_request(REQ_READ, 8'd0, 7'd127, 6'd0);
    send_request(REQ_READ, 8'd128, 7'd127, 6'd0);
    send_request(REQ_READ, 8'd127, 7'd9, 6'd0);
  endtask

  task automatic test_unused_kind();
    send_request(REQ_UNUSED, 8'd0, 7'd127, 6'd63);
    send_request(REQ_UNUSED, 8'd255, 7'd0, 6'd0);
    send_request(REQ_READ, 8'd255, 7'd127, 6'd0);
  endtask

  task automatic test_output_holdoff();
    sink_hold_cycles = HOLDOFF_CYCLES;
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) begin
        send_request(REQ_PLACE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                     6'($urandom_range(1, 4)));
      end else begin
        send_request(REQ_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                     6'($urandom_range(0, 63)));
      end
    end
  endtask

  task automatic test_drain_pause();
    send_request(REQ_PLACE, 8'd40, 7'd20, 6'd3);
    send_request(REQ_TICK, 8'd0, 7'd0, 6'd0);
    wait_results_drained();
    send_request(REQ_READ, 8'd40, 7'd127, 6'd0);
  endtask

  task automatic test_random_traffic(input int count);
    int unsigned pick;
    int unsigned x;
    int unsigned y;
    int unsigned r;
    logic [REQ_W-1:0] kind;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      x = $urandom_range(0, 255);
      y = $urandom_range(0, 127);
      r = $urandom_range(0, 63);
      if (pick < 20) begin
        kind = REQ_TICK;
      end else if (pick < 50) begin
        kind = REQ_PLACE;
        if ($urandom_range(0, 9) != 0) r = $urandom_range(0, 8);
        last_x = x;
        last_y = y;
      end else if (pick < 95) begin
        kind = REQ_READ;
        case ($urandom_range(0, 3))
          0: begin
            x = (last_x + $urandom_range(0, 16) - 8) & 8'hFF;
            y = (last_y + $urandom_range(0, 16) - 8) & 7'h7F;
          end
          1: begin
            x = (last_x + $urandom_range(0, 8) - 4) & 8'hFF;
            y = ROWS - 1 - $urandom_range(0, 3);
          end
          default: begin
          end
        endcase
      end else begin
        kind = REQ_UNUSED;
      end
      send_request(kind, x[POS_X_W-1:0], y[POS_Y_W-1:0], r[RADIUS_W-1:0]);
    end
  endtask

  task automatic test_steady_stream(input int count);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random_traffic(count);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold_cycles - 1) @(negedge clk);
        sink_hold_cycles = 0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin : check_ack
      sand_ack_t want;
      if (pending_acks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: ack_kind %0d cell_occupied %0d",
                   m_axis_tuser, m_axis_tdata[0]);
        end
      end else begin
        want = pending_acks.pop_front();
        if (m_axis_tuser !== want.ack_kind || m_axis_tdata[0] !== want.cell_occupied) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected ack_kind %0d cell_occupied %0d, got %0d %0d",
                     want.ack_kind, want.cell_occupied, m_axis_tuser, m_axis_tdata[0]);
          end
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_TICK;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    sink_hold_cycles = 0;
    mismatches = 0;
    last_x = 0;
    last_y = 0;
    foreach (sand_rows[i]) sand_rows[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_grid();
    test_brush_clipping();
    test_sweep();
    test_unused_kind();
    test_output_holdoff();
    test_drain_pause();
    test_random_traffic(45);
    test_steady_stream(25);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
